### sv/mdam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdam_pkg
// Shared codes and state names of the array address mapper.
// ----------------------------------------------------------------------------
package mdam_pkg;

  // Item command codes
  typedef enum logic [1:0] {
    CMD_HEADER   = 2'd0,
    CMD_BOUND    = 2'd1,
    CMD_FINALIZE = 2'd2,
    CMD_INDEX    = 2'd3
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_IDX_ACC,
    ST_EMIT,
    ST_FIN_RD,
    ST_FIN_LO,
    ST_FIN_EXT,
    ST_FIN_END
  } state_e;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SIZE_W = 16;

endpackage

### sv/mdam_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdam_req_if
// Input channel: one command item per handshake.
// ----------------------------------------------------------------------------
interface mdam_req_if
  import mdam_pkg::*;
();
  logic               valid;
  logic               ready;
  cmd_e               cmd;
  logic        [3:0]  slot;
  logic        [3:0]  dim;
  logic signed [31:0] array_base;
  logic        [15:0] element_size;
  logic        [3:0]  dim_count;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic signed [31:0] index_value;
  logic               last_index;

  modport source (
    output valid, cmd, slot, dim, array_base, element_size, dim_count,
           lower_bound, upper_bound, index_value, last_index,
    input  ready
  );

  modport sink (
    input  valid, cmd, slot, dim, array_base, element_size, dim_count,
           lower_bound, upper_bound, index_value, last_index,
    output ready
  );
endinterface

### sv/mdam_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdam_rsp_if
// Output channel: one computed address per handshake.
// ----------------------------------------------------------------------------
interface mdam_rsp_if ();
  logic               valid;
  logic               ready;
  logic        [3:0]  out_slot;
  logic signed [31:0] address;

  modport source (
    output valid, out_slot, address,
    input  ready
  );

  modport sink (
    input  valid, out_slot, address,
    output ready
  );
endinterface

### sv/multidim_array_address_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multidim_array_address_mapper_unit
// Row-major array address mapper: descriptor tables in two synchronous
// memories, a shared 32x32 multiplier and a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake        Carries
//  req_i    in   valid / ready    cmd, slot, dim, header, bound, index fields
//  rsp_o    out  valid / ready    out_slot, address
//
// Steps: header and bound items pass IDLE and EXEC, an index item also
//   IDX_ACC, a last index also EMIT (which holds while an earlier address
//   still waits unaccepted in the output register). Finalize runs RD, LO and
//   EXT per dimension, then END; the walk issues one read of the dimension
//   memory per dimension and runs two products through the single multiplier.
// Reset: clears the sequencer, the accumulator and the output valid only;
//   descriptor memories are not cleared and hold nothing until written.
// Stalls: items are taken only in IDLE, so every memory write lands before
//   the next read and no forwarding is needed. A waiting result does not
//   block new items; only the next last index waits for it.
// ----------------------------------------------------------------------------
module multidim_array_address_mapper_unit
  import mdam_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned MAX_DIMS  = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mdam_req_if.sink     req_i,
  mdam_rsp_if.source   rsp_o
);

  // Address and count widths
  localparam int unsigned SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned SLOT_CW = SLOT_AW + 5;
  localparam int unsigned DIM_DEPTH = NUM_SLOTS * MAX_DIMS;
  localparam int unsigned DIM_AW  = (DIM_DEPTH > 1) ? $clog2(DIM_DEPTH) : 1;
  localparam int unsigned ROW_CW  = DIM_AW + 5;
  localparam int unsigned DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DCNT_W  = $clog2(MAX_DIMS + 1);

  typedef struct packed {
    logic [WORD_W-1:0] base;
    logic [SIZE_W-1:0] esize;
    logic [DCNT_W-1:0] dims;
    logic [WORD_W-1:0] cnst;
  } slot_rec_t;

  typedef struct packed {
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] coef;
  } dim_rec_t;

  // Descriptor memories
  slot_rec_t slot_mem [NUM_SLOTS];
  dim_rec_t  dim_mem  [DIM_DEPTH];

  logic               slot_we, slot_re;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  slot_rec_t          slot_wdata, slot_rd_q;

  logic               dim_we, dim_re;
  logic [DIM_AW-1:0]  dim_waddr, dim_raddr;
  dim_rec_t           dim_wdata, dim_rd_q;

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dim_we) begin
      dim_mem[dim_waddr] <= dim_wdata;
    end
    if (dim_re) begin
      dim_rd_q <= dim_mem[dim_raddr];
    end
  end

  // Sequencer and datapath registers
  state_e             state_q, state_d;
  logic [WORD_W-1:0]  accum_q, accum_d;
  logic               out_valid_q, out_valid_d;
  logic [3:0]         out_slot_q, out_slot_d;
  logic [WORD_W-1:0]  out_addr_q, out_addr_d;

  cmd_e               cmd_q;
  logic [3:0]         slot_q;
  logic [3:0]         dim_q;
  logic [WORD_W-1:0]  base_q;
  logic [SIZE_W-1:0]  esize_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic [WORD_W-1:0]  lower_q, upper_q, idx_q;
  logic               last_q, slot_ok_q, dim_ok_q;
  logic [DIM_AW-1:0]  row_q;

  slot_rec_t          rec_q, rec_d;
  logic [WORD_W-1:0]  cnst_q, cnst_d;
  logic [WORD_W-1:0]  prod_q, prod_d;
  logic [WORD_W-1:0]  ext_q, ext_d;
  logic [WORD_W-1:0]  coef_q, coef_d;
  logic [DIM_W-1:0]   k_q, k_d;

  // Input decode
  logic               accept;
  logic [SLOT_CW-1:0] slot_ext;
  logic               slot_ok, dim_ok;
  logic [ROW_CW-1:0]  row_sum;
  logic [4:0]         dcnt_sat;

  assign accept   = req_i.valid && req_i.ready;
  assign slot_ext = SLOT_CW'(req_i.slot);
  assign slot_ok  = slot_ext < SLOT_CW'(NUM_SLOTS);
  assign dim_ok   = 5'(req_i.dim) < 5'(MAX_DIMS);
  assign row_sum  = ROW_CW'(req_i.slot) * ROW_CW'(MAX_DIMS);
  assign dcnt_sat = (5'(req_i.dim_count) > 5'(MAX_DIMS)) ? 5'(MAX_DIMS)
                                                         : 5'(req_i.dim_count);

  // Shared multiplier, low word only
  logic [WORD_W-1:0] mul_a, mul_b, mul_p;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (state_q)
      ST_FIN_LO: begin
        mul_a = coef_q;
        mul_b = dim_rd_q.lower;
      end
      ST_FIN_EXT: begin
        mul_a = ext_q;
        mul_b = coef_q;
      end
      default: begin
        mul_a = dim_rd_q.coef;
        mul_b = idx_q;
      end
    endcase
  end

  logic idx_adds;
  assign idx_adds = slot_ok_q && dim_ok_q && (5'(dim_q) < 5'(slot_rd_q.dims));

  assign req_i.ready    = (state_q == ST_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.out_slot = out_slot_q;
  assign rsp_o.address  = out_addr_q;

  always_comb begin
    state_d     = state_q;
    accum_d     = accum_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_slot_d  = out_slot_q;
    out_addr_d  = out_addr_q;
    rec_d       = rec_q;
    cnst_d      = cnst_q;
    prod_d      = prod_q;
    ext_d       = ext_q;
    coef_d      = coef_q;
    k_d         = k_q;

    slot_re    = 1'b0;
    slot_raddr = slot_ext[SLOT_AW-1:0];
    slot_we    = 1'b0;
    slot_waddr = SLOT_AW'(slot_q);
    slot_wdata = slot_rd_q;
    dim_re     = 1'b0;
    dim_raddr  = row_sum[DIM_AW-1:0] + DIM_AW'(req_i.dim);
    dim_we     = 1'b0;
    dim_waddr  = row_q + DIM_AW'(dim_q);
    dim_wdata  = dim_rd_q;

    unique case (state_q)
      ST_IDLE: begin
        // Read both tables for the item as it is taken
        if (accept) begin
          slot_re = 1'b1;
          dim_re  = 1'b1;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (cmd_q)
          CMD_HEADER: begin
            // Keep the stored constant, replace the header fields
            slot_we          = slot_ok_q;
            slot_wdata.base  = base_q;
            slot_wdata.esize = esize_q;
            slot_wdata.dims  = dcnt_q;
            state_d          = ST_IDLE;
          end
          CMD_BOUND: begin
            dim_we          = slot_ok_q && dim_ok_q;
            dim_wdata.lower = lower_q;
            dim_wdata.upper = upper_q;
            state_d         = ST_IDLE;
          end
          CMD_FINALIZE: begin
            rec_d  = slot_rd_q;
            cnst_d = slot_rd_q.base;
            coef_d = WORD_W'(slot_rd_q.esize);
            k_d    = DIM_W'(5'(slot_rd_q.dims) - 5'd1);
            if (!slot_ok_q) begin
              state_d = ST_IDLE;
            end else if (slot_rd_q.dims == '0) begin
              state_d = ST_FIN_END;
            end else begin
              state_d = ST_FIN_RD;
            end
          end
          CMD_INDEX: begin
            // Drop the term when the slot or dimension is out of range, or the dimension is not below the slot's count
            prod_d  = idx_adds ? mul_p : '0;
            cnst_d  = slot_ok_q ? slot_rd_q.cnst : '0;
            state_d = ST_IDX_ACC;
          end
        endcase
      end

      ST_IDX_ACC: begin
        accum_d = accum_q + prod_q;
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_slot_d  = slot_q;
          out_addr_d  = cnst_q + accum_q;
          accum_d     = '0;
          state_d     = ST_IDLE;
        end
      end

      ST_FIN_RD: begin
        dim_re    = 1'b1;
        dim_raddr = row_q + DIM_AW'(k_q);
        state_d   = ST_FIN_LO;
      end

      ST_FIN_LO: begin
        // Store this dimension's coefficient, start its lower-bound product
        dim_we         = 1'b1;
        dim_waddr      = row_q + DIM_AW'(k_q);
        dim_wdata.coef = coef_q;
        prod_d         = mul_p;
        ext_d          = dim_rd_q.upper - dim_rd_q.lower + WORD_W'(1);
        state_d        = ST_FIN_EXT;
      end

      ST_FIN_EXT: begin
        // Subtract the lower-bound term, advance the coefficient downward
        cnst_d = cnst_q - prod_q;
        coef_d = mul_p;
        if (k_q == '0) begin
          state_d = ST_FIN_END;
        end else begin
          k_d     = k_q - DIM_W'(1);
          state_d = ST_FIN_RD;
        end
      end

      ST_FIN_END: begin
        slot_we         = 1'b1;
        slot_wdata      = rec_q;
        slot_wdata.cnst = cnst_q;
        state_d         = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      accum_q     <= accum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    out_slot_q <= out_slot_d;
    out_addr_q <= out_addr_d;
    rec_q      <= rec_d;
    cnst_q     <= cnst_d;
    prod_q     <= prod_d;
    ext_q      <= ext_d;
    coef_q     <= coef_d;
    k_q        <= k_d;
    if (accept) begin
      cmd_q     <= req_i.cmd;
      slot_q    <= req_i.slot;
      dim_q     <= req_i.dim;
      base_q    <= req_i.array_base;
      esize_q   <= req_i.element_size;
      dcnt_q    <= dcnt_sat[DCNT_W-1:0];
      lower_q   <= req_i.lower_bound;
      upper_q   <= req_i.upper_bound;
      idx_q     <= req_i.index_value;
      last_q    <= req_i.last_index;
      slot_ok_q <= slot_ok;
      dim_ok_q  <= dim_ok;
      row_q     <= row_sum[DIM_AW-1:0];
    end
  end

`ifndef ASSERT_OFF
  // The finalize walk stays inside the descriptor row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN_RD) |-> (5'(k_q) < 5'(MAX_DIMS)))
    else $error("finalize dimension counter out of range");

  // A new address clears the accumulator for the next reference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_q || rsp_o.ready)) |=> (accum_q == '0))
    else $error("accumulator not cleared after address");

  // Only a last index reaches the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDX_ACC && !last_q) |=> (state_q == ST_IDLE))
    else $error("non-last index produced an address");

  // Table writes never target an out-of-range slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_we || dim_we) |-> slot_ok_q)
    else $error("table write for invalid slot");

  // No table write while a new item is being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(slot_we || dim_we))
    else $error("table write overlaps item read");
`endif

endmodule
